FILE: design/ps2sa_pkg.sv
// Shared constants, widths and key translation tables for the scancode to ASCII block.
package ps2sa_pkg;

  // Default ring depth (slots; one slot always stays free)
  localparam int unsigned QUEUE_DEPTH_DEFAULT = 32;

  localparam int unsigned SCAN_W  = 8;
  localparam int unsigned KEY_W   = 7;
  localparam int unsigned CHAR_W  = 7;
  localparam int unsigned TABLE_W = 6;

  // Set 1 key codes with a special meaning
  localparam logic [KEY_W-1:0] KEY_LSHIFT = 7'h2A;
  localparam logic [KEY_W-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KEY_W-1:0] KEY_CTRL   = 7'h1D;
  localparam logic [KEY_W-1:0] KEY_ALT    = 7'h38;
  localparam logic [KEY_W-1:0] KEY_CAPS   = 7'h3A;

  // Operation codes of an input beat
  localparam logic OP_SCAN = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [CHAR_W-1:0] CHAR_NONE    = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'h7A;
  localparam logic [CHAR_W-1:0] CHAR_CASE    = 7'h20;

  // Unshifted US layout for key codes 0x00-0x3F
  function automatic logic [CHAR_W-1:0] plain_char(input logic [TABLE_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      6'h01: ch = 7'h1B;  // escape
      6'h02: ch = 7'h31;
      6'h03: ch = 7'h32;
      6'h04: ch = 7'h33;
      6'h05: ch = 7'h34;
      6'h06: ch = 7'h35;
      6'h07: ch = 7'h36;
      6'h08: ch = 7'h37;
      6'h09: ch = 7'h38;
      6'h0A: ch = 7'h39;
      6'h0B: ch = 7'h30;
      6'h0C: ch = 7'h2D;
      6'h0D: ch = 7'h3D;
      6'h0E: ch = 7'h08;  // backspace
      6'h0F: ch = 7'h09;  // tab
      6'h10: ch = 7'h71;
      6'h11: ch = 7'h77;
      6'h12: ch = 7'h65;
      6'h13: ch = 7'h72;
      6'h14: ch = 7'h74;
      6'h15: ch = 7'h79;
      6'h16: ch = 7'h75;
      6'h17: ch = 7'h69;
      6'h18: ch = 7'h6F;
      6'h19: ch = 7'h70;
      6'h1A: ch = 7'h5B;
      6'h1B: ch = 7'h5D;
      6'h1C: ch = 7'h0A;  // enter
      6'h1E: ch = 7'h61;
      6'h1F: ch = 7'h73;
      6'h20: ch = 7'h64;
      6'h21: ch = 7'h66;
      6'h22: ch = 7'h67;
      6'h23: ch = 7'h68;
      6'h24: ch = 7'h6A;
      6'h25: ch = 7'h6B;
      6'h26: ch = 7'h6C;
      6'h27: ch = 7'h3B;
      6'h28: ch = 7'h27;
      6'h29: ch = 7'h60;
      6'h2B: ch = 7'h5C;
      6'h2C: ch = 7'h7A;
      6'h2D: ch = 7'h78;
      6'h2E: ch = 7'h63;
      6'h2F: ch = 7'h76;
      6'h30: ch = 7'h62;
      6'h31: ch = 7'h6E;
      6'h32: ch = 7'h6D;
      6'h33: ch = 7'h2C;
      6'h34: ch = 7'h2E;
      6'h35: ch = 7'h2F;
      6'h37: ch = 7'h2A;
      6'h39: ch = 7'h20;  // space
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

  // Shifted symbols; letters are handled by case folding, the rest match the plain table
  function automatic logic [CHAR_W-1:0] shifted_char(input logic [TABLE_W-1:0] key);
    logic [CHAR_W-1:0] ch;
    case (key)
      6'h02: ch = 7'h21;
      6'h03: ch = 7'h40;
      6'h04: ch = 7'h23;
      6'h05: ch = 7'h24;
      6'h06: ch = 7'h25;
      6'h07: ch = 7'h5E;
      6'h08: ch = 7'h26;
      6'h09: ch = 7'h2A;
      6'h0A: ch = 7'h28;
      6'h0B: ch = 7'h29;
      6'h0C: ch = 7'h5F;
      6'h0D: ch = 7'h2B;
      6'h1A: ch = 7'h7B;
      6'h1B: ch = 7'h7D;
      6'h27: ch = 7'h3A;
      6'h28: ch = 7'h22;
      6'h29: ch = 7'h7E;
      6'h2B: ch = 7'h7C;
      6'h33: ch = 7'h3C;
      6'h34: ch = 7'h3E;
      6'h35: ch = 7'h3F;
      default: ch = plain_char(key);
    endcase
    return ch;
  endfunction

endpackage

FILE: design/ps2sa_if.sv
// Valid/ready channel interfaces for the request and result beats.
interface ps2sa_req_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] scan_byte;

  modport source (output valid, output operation, output scan_byte, input ready);
  modport sink   (input valid, input operation, input scan_byte, output ready);
endinterface

interface ps2sa_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] ascii_char;
  logic       queue_has_data;
  logic       char_dropped;
  logic       ctrl_down;
  logic       alt_down;
  logic       caps_active;

  modport source (output valid, output ascii_char, output queue_has_data,
                  output char_dropped, output ctrl_down, output alt_down,
                  output caps_active, input ready);
  modport sink   (input valid, input ascii_char, input queue_has_data,
                  input char_dropped, input ctrl_down, input alt_down,
                  input caps_active, output ready);
endinterface

FILE: design/ps2sa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ps2sa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, held while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/ps2_set1_scancode_to_ascii_fifo.sv
// PS/2 set 1 scancode translator with a character ring, top level.
//
// Each request beat is either a scancode byte or a read of one queued character; each
// gives exactly one result beat, registered in the cycle after acceptance. One beat is taken
// every cycle while the result side keeps up: the request is translated and the ring
// pointers and modifier flags are updated in the accepting cycle, and a popped character
// is read from the ring RAM into its read register, which then carries ascii_char. The
// ring has QUEUE_DEPTH slots and holds at most QUEUE_DEPTH-1 characters; a character that
// finds it full is discarded and flagged in char_dropped. No clearing pass is needed after
// reset: a read only ever reaches entries already written.
module ps2_set1_scancode_to_ascii_fifo #(
  parameter int unsigned QUEUE_DEPTH = ps2sa_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  ps2sa_req_if.sink     req,
  ps2sa_rsp_if.source   rsp
);
  import ps2sa_pkg::*;

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

  // Architectural state
  logic             shift_down, caps_on, ctrl_held, alt_held;
  logic [IDX_W-1:0] write_index, read_index;

  logic             shift_down_next, caps_on_next, ctrl_held_next, alt_held_next;
  logic [IDX_W-1:0] write_index_next, read_index_next;
  logic [IDX_W-1:0] write_inc, read_inc;

  // Result register
  logic out_valid, out_pop, out_has_data, out_dropped;
  logic out_ctrl, out_alt, out_caps;
  logic [CHAR_W-1:0] ram_rdata;

  logic              accept, is_scan, release_key, in_table;
  logic [KEY_W-1:0]  key;
  logic [CHAR_W-1:0] base_char, xlat_char;
  logic              is_letter, push, drop, pop, full, empty;

  assign req.ready = !rst && (!out_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  assign is_scan     = (req.operation == OP_SCAN);
  assign release_key = req.scan_byte[SCAN_W-1];
  assign key         = req.scan_byte[KEY_W-1:0];
  assign in_table    = (key[KEY_W-1] == 1'b0);

  // Modifier decode
  always_comb begin
    shift_down_next = shift_down;
    caps_on_next    = caps_on;
    ctrl_held_next  = ctrl_held;
    alt_held_next   = alt_held;
    if (is_scan) begin
      unique case (key) inside
        KEY_LSHIFT, KEY_RSHIFT: shift_down_next = !release_key;
        KEY_CTRL:               ctrl_held_next  = !release_key;
        KEY_ALT:                alt_held_next   = !release_key;
        KEY_CAPS:               caps_on_next    = caps_on ^ !release_key;
        default: ;
      endcase
    end
  end

  // Translate a key press; modifier codes map to zero in both tables
  assign base_char = plain_char(key[TABLE_W-1:0]);
  assign is_letter = (base_char >= CHAR_LOWER_A) && (base_char <= CHAR_LOWER_Z);

  always_comb begin
    xlat_char = CHAR_NONE;
    if (is_scan && !release_key && in_table) begin
      if (is_letter) begin
        xlat_char = (caps_on ^ shift_down) ? base_char - CHAR_CASE : base_char;
      end else if (shift_down) begin
        xlat_char = shifted_char(key[TABLE_W-1:0]);
      end else begin
        xlat_char = base_char;
      end
    end
  end

  // Ring pointers, wrapping at any depth
  assign write_inc = (write_index == IDX_LAST) ? '0 : write_index + 1'b1;
  assign read_inc  = (read_index  == IDX_LAST) ? '0 : read_index  + 1'b1;
  assign full      = (write_inc == read_index);
  assign empty     = (write_index == read_index);

  assign push = accept && (xlat_char != CHAR_NONE) && !full;
  assign drop = (xlat_char != CHAR_NONE) && full;
  assign pop  = accept && !is_scan && !empty;

  assign write_index_next = push ? write_inc : write_index;
  assign read_index_next  = pop  ? read_inc  : read_index;

  // Advance state on an accepted beat
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_down  <= 1'b0;
      caps_on     <= 1'b0;
      ctrl_held   <= 1'b0;
      alt_held    <= 1'b0;
      write_index <= '0;
      read_index  <= '0;
    end else if (accept) begin
      shift_down  <= shift_down_next;
      caps_on     <= caps_on_next;
      ctrl_held   <= ctrl_held_next;
      alt_held    <= alt_held_next;
      write_index <= write_index_next;
      read_index  <= read_index_next;
    end
  end

  // Character ring
  ps2sa_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (push),
    .waddr (write_index),
    .wdata (xlat_char),
    .re    (pop),
    .raddr (read_index),
    .rdata (ram_rdata)
  );

  // Result valid: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= accept || (out_valid && !rsp.ready);
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_pop      <= pop;
      out_has_data <= (write_index_next != read_index_next);
      out_dropped  <= drop;
      out_ctrl     <= ctrl_held_next;
      out_alt      <= alt_held_next;
      out_caps     <= caps_on_next;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.ascii_char     = out_pop ? ram_rdata : CHAR_NONE;
  assign rsp.queue_has_data = out_has_data;
  assign rsp.char_dropped   = out_dropped;
  assign rsp.ctrl_down      = out_ctrl;
  assign rsp.alt_down       = out_alt;
  assign rsp.caps_active    = out_caps;

endmodule

FILE: design/ps2sa_checker.sv
// Port-level checks for the scancode translator, bound to the top level.
module ps2sa_checker (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic       req_operation,
  input logic [7:0] req_scan_byte,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [6:0] rsp_ascii_char,
  input logic       rsp_queue_has_data,
  input logic       rsp_char_dropped,
  input logic       rsp_ctrl_down,
  input logic       rsp_alt_down,
  input logic       rsp_caps_active
);
  import ps2sa_pkg::*;

  logic [11:0] rsp_payload;
  assign rsp_payload = {rsp_ascii_char, rsp_queue_has_data, rsp_char_dropped,
                        rsp_ctrl_down, rsp_alt_down, rsp_caps_active};

  // No result beat straight after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("result beat valid after reset");

  // A stalled result beat holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
    else $error("stalled result beat changed");

  // A dropped character means the ring is full, so it still has data
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
      rsp_valid && rsp_char_dropped |-> rsp_queue_has_data && rsp_ascii_char == CHAR_NONE)
    else $error("drop reported with empty ring or a popped character");

  // A ctrl press shows as held in the very next result beat
  a_ctrl_press: assert property (@(posedge clk) disable iff (rst)
      req_valid && req_ready && req_operation == OP_SCAN && req_scan_byte == {1'b0, KEY_CTRL}
      |=> rsp_valid && rsp_ctrl_down)
    else $error("ctrl press not reflected in result");

  // A scancode beat never pops, so the next result carries no character
  a_scan_no_char: assert property (@(posedge clk) disable iff (rst)
      req_valid && req_ready && req_operation == OP_SCAN |=> rsp_ascii_char == CHAR_NONE)
    else $error("character returned on a scancode beat");

endmodule

bind ps2_set1_scancode_to_ascii_fifo ps2sa_checker u_ps2sa_checker (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .req_operation      (req.operation),
  .req_scan_byte      (req.scan_byte),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_ascii_char     (rsp.ascii_char),
  .rsp_queue_has_data (rsp.queue_has_data),
  .rsp_char_dropped   (rsp.char_dropped),
  .rsp_ctrl_down      (rsp.ctrl_down),
  .rsp_alt_down       (rsp.alt_down),
  .rsp_caps_active    (rsp.caps_active)
);

FILE: verif/ps2_set1_scancode_to_ascii_fifo_test.sv
// Testbench for the PS/2 set 1 scancode to ASCII translator with its character ring.
module ps2_set1_scancode_to_ascii_fifo_test;
  import ps2sa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RING_SLOTS   = QUEUE_DEPTH_DEFAULT;
  localparam int unsigned RANDOM_COUNT = 900;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned DRAIN_CYCLES = 10;

  localparam logic [SCAN_W-1:0] RELEASE_BIT = 8'h80;

  typedef struct packed {
    logic              operation;
    logic [SCAN_W-1:0] scan_byte;
  } key_event_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ascii_char;
    logic              queue_has_data;
    logic              char_dropped;
    logic              ctrl_down;
    logic              alt_down;
    logic              caps_active;
  } key_report_t;

  logic clk;
  logic rst;

  ps2sa_req_if req_ch ();
  ps2sa_rsp_if rsp_ch ();

  ps2_set1_scancode_to_ascii_fifo dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // US layout, unshifted and shifted, key codes 0x00-0x3F
  logic [CHAR_W-1:0] plain_keys [64] = '{
    7'h00, 7'h1B, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6F, 7'h70, 7'h5B, 7'h5D, 7'h0A, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C, 7'h3B,
    7'h27, 7'h60, 7'h00, 7'h5C, 7'h7A, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6E, 7'h6D, 7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };
  logic [CHAR_W-1:0] shifted_keys [64] = '{
    7'h00, 7'h1B, 7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E,
    7'h26, 7'h2A, 7'h28, 7'h29, 7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49,
    7'h4F, 7'h50, 7'h7B, 7'h7D, 7'h0A, 7'h00, 7'h41, 7'h53,
    7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C, 7'h3A,
    7'h22, 7'h7E, 7'h00, 7'h7C, 7'h5A, 7'h58, 7'h43, 7'h56,
    7'h42, 7'h4E, 7'h4D, 7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
  };

  // Predicted keyboard state
  logic              shift_held;
  logic              caps_toggled;
  logic              ctrl_held;
  logic              alt_held;
  logic [CHAR_W-1:0] typed_chars [$];

  key_event_t  pending_events   [$];
  key_report_t expected_reports [$];

  int unsigned fail_count;
  int unsigned reports_seen;
  int unsigned idle_cycles;
  int unsigned send_gap;
  int unsigned recv_stall;
  bit          send_quiet;
  bit          recv_quiet;

  // Work out the report for one accepted request and advance the predicted state
  function automatic key_report_t translate_event(input key_event_t ev);
    key_report_t       rep;
    logic              released;
    logic [KEY_W-1:0]  key;
    logic [CHAR_W-1:0] ch;
    ch       = CHAR_NONE;
    released = ev.scan_byte[SCAN_W-1];
    key      = ev.scan_byte[KEY_W-1:0];
    rep      = '0;
    if (ev.operation == OP_SCAN) begin
      if (key == KEY_LSHIFT || key == KEY_RSHIFT) begin
        shift_held = !released;
      end else if (key == KEY_CTRL) begin
        ctrl_held = !released;
      end else if (key == KEY_ALT) begin
        alt_held = !released;
      end else if (key == KEY_CAPS) begin
        if (!released) caps_toggled = !caps_toggled;
      end else if (!released && key[KEY_W-1] == 1'b0) begin
        ch = plain_keys[key[TABLE_W-1:0]];
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
          if (caps_toggled != shift_held) ch = ch - CHAR_CASE;
        end else if (shift_held) begin
          ch = shifted_keys[key[TABLE_W-1:0]];
        end
      end
      if (ch != CHAR_NONE) begin
        if (typed_chars.size() < RING_SLOTS - 1) typed_chars.push_back(ch);
        else rep.char_dropped = 1'b1;
      end
    end else if (typed_chars.size() != 0) begin
      rep.ascii_char = typed_chars.pop_front();
    end
    rep.queue_has_data = (typed_chars.size() != 0);
    rep.ctrl_down      = ctrl_held;
    rep.alt_down       = alt_held;
    rep.caps_active    = caps_toggled;
    return rep;
  endfunction

  // Mostly short gaps, a few long ones, none at all in quiet stretches
  function automatic int unsigned pick_gap(input bit quiet);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (quiet || roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_scan(input logic [SCAN_W-1:0] code);
    key_event_t ev;
    ev.operation = OP_SCAN;
    ev.scan_byte = code;
    pending_events.push_back(ev);
  endtask

  task automatic push_read();
    key_event_t ev;
    ev.operation = OP_READ;
    ev.scan_byte = SCAN_W'($urandom_range(0, 255));
    pending_events.push_back(ev);
  endtask

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Request driver: predict on each accepted beat, then offer the next one
  always @(posedge clk) begin
    key_event_t ev;
    if (rst) begin
      req_ch.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        ev.operation = req_ch.operation;
        ev.scan_byte = req_ch.scan_byte;
        expected_reports.push_back(translate_event(ev));
      end
      if (!req_ch.valid || req_ch.ready) begin
        if ($urandom_range(0, 63) == 0) send_quiet = !send_quiet;
        if (send_gap > 0) begin
          send_gap = send_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          ev = pending_events.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= ev.operation;
          req_ch.scan_byte <= ev.scan_byte;
          send_gap = pick_gap(send_quiet);
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each beat against the oldest prediction, then pick the stall
  always @(posedge clk) begin
    key_report_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected result beat: ascii_char %h", rsp_ch.ascii_char);
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          if (rsp_ch.ascii_char !== want.ascii_char) begin
            $error("ascii_char: expected %h, got %h", want.ascii_char, rsp_ch.ascii_char);
            fail_count++;
          end
          if (rsp_ch.queue_has_data !== want.queue_has_data) begin
            $error("queue_has_data: expected %b, got %b",
                   want.queue_has_data, rsp_ch.queue_has_data);
            fail_count++;
          end
          if (rsp_ch.char_dropped !== want.char_dropped) begin
            $error("char_dropped: expected %b, got %b",
                   want.char_dropped, rsp_ch.char_dropped);
            fail_count++;
          end
          if (rsp_ch.ctrl_down !== want.ctrl_down) begin
            $error("ctrl_down: expected %b, got %b", want.ctrl_down, rsp_ch.ctrl_down);
            fail_count++;
          end
          if (rsp_ch.alt_down !== want.alt_down) begin
            $error("alt_down: expected %b, got %b", want.alt_down, rsp_ch.alt_down);
            fail_count++;
          end
          if (rsp_ch.caps_active !== want.caps_active) begin
            $error("caps_active: expected %b, got %b", want.caps_active, rsp_ch.caps_active);
            fail_count++;
          end
        end
        reports_seen++;
        if ($urandom_range(0, 63) == 0) recv_quiet = !recv_quiet;
        recv_stall = pick_gap(recv_quiet);
        // Hold off for a long stretch so the block fills and stalls its input
        if (reports_seen == 100 || reports_seen == 600) recv_stall = HOLD_CYCLES;
      end
      if (recv_stall > 0) begin
        recv_stall = recv_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int unsigned kind;
    int unsigned burst;
    logic [SCAN_W-1:0] code;

    rst              = 1'b1;
    req_ch.valid     = 1'b0;
    req_ch.operation = OP_SCAN;
    req_ch.scan_byte = '0;
    rsp_ch.ready     = 1'b0;
    shift_held       = 1'b0;
    caps_toggled     = 1'b0;
    ctrl_held        = 1'b0;
    alt_held         = 1'b0;
    fail_count       = 0;
    reports_seen     = 0;
    idle_cycles      = 0;
    send_quiet       = 1'b0;
    recv_quiet       = 1'b0;

    // Directed: empty read, plain and shifted keys, caps lock, modifiers, dead codes
    push_read();
    push_scan(8'h00);
    push_scan(8'h1E);
    push_scan({1'b0, KEY_LSHIFT});
    push_scan(8'h1E);
    push_scan(8'h02);
    push_scan(RELEASE_BIT | {1'b0, KEY_LSHIFT});
    push_scan({1'b0, KEY_RSHIFT});
    push_scan(8'h0C);
    push_scan(RELEASE_BIT | {1'b0, KEY_RSHIFT});
    push_scan({1'b0, KEY_CAPS});
    push_scan(RELEASE_BIT | {1'b0, KEY_CAPS});
    push_scan(8'h10);
    push_scan({1'b0, KEY_LSHIFT});
    push_scan(8'h10);
    push_scan(8'h02);
    push_scan(RELEASE_BIT | {1'b0, KEY_LSHIFT});
    push_scan({1'b0, KEY_CAPS});
    push_scan({1'b0, KEY_CTRL});
    push_scan({1'b0, KEY_ALT});
    push_scan(8'h40);
    push_scan(8'h7F);
    push_scan(8'h9E);
    push_scan(8'hFF);
    push_scan(RELEASE_BIT | {1'b0, KEY_CTRL});
    push_scan(RELEASE_BIT | {1'b0, KEY_ALT});
    repeat (12) push_read();

    // Random: typing runs that fill the ring, drains, modifier traffic and noise
    while (pending_events.size() < RANDOM_COUNT + 40) begin
      kind = $urandom_range(0, 9);
      if (kind <= 3) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 2) == 0) push_scan({1'b0, $urandom_range(0, 1) ? KEY_LSHIFT
                                                                            : KEY_RSHIFT});
        repeat (burst) begin
          code = ($urandom_range(0, 15) == 0) ? SCAN_W'($urandom_range(8'h40, 8'h7F))
                                              : SCAN_W'($urandom_range(8'h00, 8'h3F));
          push_scan(code);
          if ($urandom_range(0, 3) == 0) push_scan(code | RELEASE_BIT);
          if ($urandom_range(0, 7) == 0) push_read();
        end
        if ($urandom_range(0, 1) == 0) push_scan(RELEASE_BIT | {1'b0, KEY_LSHIFT});
        if ($urandom_range(0, 1) == 0) push_scan(RELEASE_BIT | {1'b0, KEY_RSHIFT});
      end else if (kind <= 5) begin
        repeat ($urandom_range(1, 40)) push_read();
      end else if (kind == 6) begin
        case ($urandom_range(0, 4))
          0:       code = {1'b0, KEY_LSHIFT};
          1:       code = {1'b0, KEY_RSHIFT};
          2:       code = {1'b0, KEY_CTRL};
          3:       code = {1'b0, KEY_ALT};
          default: code = {1'b0, KEY_CAPS};
        endcase
        push_scan($urandom_range(0, 1) ? (code | RELEASE_BIT) : code);
      end else begin
        repeat ($urandom_range(1, 10)) begin
          if ($urandom_range(0, 1) == 0) push_read();
          else push_scan(SCAN_W'($urandom_range(0, 255)));
        end
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every request to go through and every result to come back
    @(negedge clk);
    while (pending_events.size() != 0 || req_ch.valid || expected_reports.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/ps2sa_pkg.sv
design/ps2sa_if.sv
design/ps2sa_ram.sv
design/ps2_set1_scancode_to_ascii_fifo.sv
design/ps2sa_checker.sv
verif/ps2_set1_scancode_to_ascii_fifo_test.sv
